[rtl/core/mweu_pkg.sv]
// Shared types, widths and codes for the maze wall evidence update block.
package mweu_pkg;

  // Default grid geometry and counter width.
  localparam int GRID_SIZE_DEF  = 16;
  localparam int COUNT_BITS_DEF = 8;

  // Fixed field widths of the words on the ports.
  localparam int CELL_W  = 4;
  localparam int DIR_W   = 2;
  localparam int RANGE_W = 12;
  localparam int BLK_W   = 10;
  localparam int OCNT_W  = 8;

  // Ray position: the cell field plus room for one step back and three forward.
  localparam int POS_W = CELL_W + 2;

  localparam logic [BLK_W-1:0] BLK_RESET = BLK_W'(180);

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic [DIR_W-1:0] DIR_EAST  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_SOUTH = 2'd1;
  localparam logic [DIR_W-1:0] DIR_WEST  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_NORTH = 2'd3;

  // Most cells a ray decrements before it stops.
  localparam logic [1:0] MAX_RAY_STEPS = 2'd3;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_READ = 2'd1,
    ACT_DEC  = 2'd2,
    ACT_INC  = 2'd3
  } act_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;   // write zero at the sweep address
    logic load;    // capture an input word
    logic fetch;   // read the counter of the current cell
    logic commit;  // write back unless reading, load the output register, advance the ray on a decrement
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    act_e act;
    logic last;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/core/mweu_if.sv]
// Valid/ready channel interfaces for the input and result words.
interface mweu_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [mweu_pkg::CELL_W-1:0]   cell_x;
  logic [mweu_pkg::CELL_W-1:0]   cell_y;
  logic [mweu_pkg::DIR_W-1:0]    look_dir;
  logic [mweu_pkg::RANGE_W-1:0]  range_reading;

  modport source (output valid, cmd, cell_x, cell_y, look_dir, range_reading,
                  input ready);
  modport sink (input valid, cmd, cell_x, cell_y, look_dir, range_reading,
                output ready);
endinterface

interface mweu_out_if;
  logic                               valid;
  logic                               ready;
  logic [mweu_pkg::CELL_W-1:0]        out_x;
  logic [mweu_pkg::CELL_W-1:0]        out_y;
  logic                               wall_kind;
  logic signed [mweu_pkg::OCNT_W-1:0] new_count;
  logic                               touched;
  logic                               last;

  modport source (output valid, out_x, out_y, wall_kind, new_count, touched, last,
                  input ready);
  modport sink (input valid, out_x, out_y, wall_kind, new_count, touched, last,
                output ready);
endinterface

[rtl/core/mweu_dp.sv]
// Datapath: configuration register, counter memory, ray registers and output register.
module mweu_dp #(
  parameter int GRID_SIZE  = mweu_pkg::GRID_SIZE_DEF,
  parameter int COUNT_BITS = mweu_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mweu_pkg::BLK_W-1:0]    cfg_wdata_i,
  input  mweu_pkg::dp_cmd_t             cmd_i,
  output mweu_pkg::dp_stat_t            stat_o,
  input  logic                          in_cmd_i,
  input  logic [mweu_pkg::CELL_W-1:0]   in_cell_x_i,
  input  logic [mweu_pkg::CELL_W-1:0]   in_cell_y_i,
  input  logic [mweu_pkg::DIR_W-1:0]    in_look_dir_i,
  input  logic [mweu_pkg::RANGE_W-1:0]  in_range_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [mweu_pkg::CELL_W-1:0]   out_x_o,
  output logic [mweu_pkg::CELL_W-1:0]   out_y_o,
  output logic                          out_wall_o,
  output logic signed [mweu_pkg::OCNT_W-1:0] out_count_o,
  output logic                          out_touched_o,
  output logic                          out_last_o
);
  import mweu_pkg::*;

  localparam int DEPTH = 2 * GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [POS_W:0] GRID_LIM = (POS_W + 1)'(GRID_SIZE);
  localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS - 1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS - 1){1'b0}}};

  function automatic logic inside_f(logic signed [POS_W-1:0] px,
                                    logic signed [POS_W-1:0] py);
    logic ok_x;
    logic ok_y;
    ok_x = !px[POS_W-1] && ({2'b00, px[POS_W-2:0]} < GRID_LIM);
    ok_y = !py[POS_W-1] && ({2'b00, py[POS_W-2:0]} < GRID_LIM);
    return ok_x && ok_y;
  endfunction

  function automatic logic [AW-1:0] addr_f(logic signed [POS_W-1:0] px,
                                           logic signed [POS_W-1:0] py,
                                           logic wall);
    int ix;
    int iy;
    ix = int'(px[POS_W-2:0]);
    iy = int'(py[POS_W-2:0]);
    return AW'((ix * GRID_SIZE + iy) * 2 + int'(wall));
  endfunction

  // Configuration.
  logic [BLK_W-1:0] block_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= BLK_RESET;
    end else if (cfg_we_i) begin
      block_size_q <= cfg_wdata_i;
    end
  end

  // Ray state.
  logic                       read_q;
  logic signed [POS_W-1:0]    x_q, y_q;
  logic [DIR_W-1:0]           dir_q;
  logic                       wall_q;
  logic [RANGE_W-1:0]         dist_q;
  logic [BLK_W-1:0]           blk_q;
  logic                       too_far_q;
  logic [1:0]                 n_q;

  // Input word decode and range clamp.
  logic [BLK_W-1:0]         blk_eff;
  logic [RANGE_W:0]         three_blk;
  logic                     too_far_c;
  logic signed [POS_W-1:0]  x_start, y_start;

  always_comb begin
    blk_eff   = (block_size_q == '0) ? BLK_W'(1) : block_size_q;
    three_blk = (RANGE_W + 1)'({blk_eff, 1'b0}) + (RANGE_W + 1)'(blk_eff);
    too_far_c = (RANGE_W + 1)'(in_range_i) > (three_blk + (RANGE_W + 1)'(1));
    x_start   = POS_W'(in_cell_x_i);
    y_start   = POS_W'(in_cell_y_i);
    if (in_cmd_i == CMD_UPDATE && in_look_dir_i == DIR_WEST) begin
      x_start = x_start - POS_W'(1);
    end
    if (in_cmd_i == CMD_UPDATE && in_look_dir_i == DIR_NORTH) begin
      y_start = y_start - POS_W'(1);
    end
  end

  // Next cell along the ray.
  logic signed [POS_W-1:0] nx, ny;
  logic [RANGE_W-1:0]      nd;

  always_comb begin
    nx = x_q;
    ny = y_q;
    unique case (dir_q)
      DIR_EAST:  nx = x_q + POS_W'(1);
      DIR_SOUTH: ny = y_q + POS_W'(1);
      DIR_WEST:  nx = x_q - POS_W'(1);
      DIR_NORTH: ny = y_q - POS_W'(1);
      default:   nx = x_q;
    endcase
    nd = dist_q - RANGE_W'(blk_q);
  end

  // Action for the current cell and whether it ends the word's results.
  logic in_c, in_n, cont_c, cont_n, fin_n;
  act_e act;
  logic last_c;

  always_comb begin
    in_c   = inside_f(x_q, y_q);
    in_n   = inside_f(nx, ny);
    cont_c = (dist_q > RANGE_W'(blk_q)) && in_c && (n_q != MAX_RAY_STEPS);
    cont_n = (nd > RANGE_W'(blk_q)) && in_n && ((n_q + 2'd1) != MAX_RAY_STEPS);
    fin_n  = !too_far_q && in_n;
    if (read_q) begin
      act = ACT_READ;
    end else if (cont_c) begin
      act = ACT_DEC;
    end else if (!too_far_q && in_c) begin
      act = ACT_INC;
    end else begin
      act = ACT_NONE;
    end
    last_c = (act == ACT_DEC) ? (!cont_n && !fin_n) : 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      read_q    <= in_cmd_i;
      x_q       <= x_start;
      y_q       <= y_start;
      dir_q     <= in_look_dir_i;
      wall_q    <= in_look_dir_i[0];
      dist_q    <= too_far_c ? three_blk[RANGE_W-1:0] : in_range_i;
      too_far_q <= (in_cmd_i == CMD_UPDATE) && too_far_c;
      blk_q     <= blk_eff;
      n_q       <= 2'd0;
    end else if (cmd_i.commit && act == ACT_DEC) begin
      x_q    <= nx;
      y_q    <= ny;
      dist_q <= nd;
      n_q    <= n_q + 2'd1;
    end
  end

  // Counter memory with its clearing sweep after reset.
  logic [AW-1:0]                  clr_q;
  logic signed [COUNT_BITS-1:0]   mem [DEPTH];
  logic signed [COUNT_BITS-1:0]   rd_q;
  logic signed [COUNT_BITS-1:0]   new_val;
  logic [AW-1:0]                  cur_addr;
  logic                           mem_we;
  logic [AW-1:0]                  wr_addr;
  logic signed [COUNT_BITS-1:0]   wr_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear && clr_q != LAST_ADDR) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  always_comb begin
    cur_addr = addr_f(x_q, y_q, wall_q);
    unique case (act)
      ACT_DEC:  new_val = (rd_q == CNT_MIN) ? rd_q : rd_q - COUNT_BITS'(1);
      ACT_INC:  new_val = (rd_q == CNT_MAX) ? rd_q : rd_q + COUNT_BITS'(1);
      ACT_READ: new_val = in_c ? rd_q : '0;
      default:  new_val = rd_q;
    endcase
    mem_we  = cmd_i.clear || (cmd_i.commit && act != ACT_READ);
    wr_addr = cmd_i.clear ? clr_q : cur_addr;
    wr_data = cmd_i.clear ? '0 : new_val;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.fetch) begin
      rd_q <= mem[cur_addr];
    end
  end

  // Output register.
  logic out_valid_q;
  int   wide_val;

  assign wide_val = int'(new_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_x_o       <= x_q[CELL_W-1:0];
      out_y_o       <= y_q[CELL_W-1:0];
      out_wall_o    <= wall_q;
      out_count_o   <= wide_val[OCNT_W-1:0];
      out_touched_o <= (act != ACT_READ);
      out_last_o    <= last_c;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign stat_o.clear_done = (clr_q == LAST_ADDR);
  assign stat_o.act        = act;
  assign stat_o.last       = last_c;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

endmodule

[rtl/core/mweu_ctrl.sv]
// Controller: clearing sweep, word intake and the read/write-back sequence per result.
module mweu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mweu_pkg::dp_stat_t   stat_i,
  output mweu_pkg::dp_cmd_t    cmd_o
);
  import mweu_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EVAL  = 4'b0100,
    S_WRITE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat_i.act == ACT_NONE) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.fetch = 1'b1;
          state_d     = S_WRITE;
        end
      end
      S_WRITE: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = stat_i.last ? S_IDLE : S_EVAL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/maze_wall_evidence_update.sv]
// Each result of a word is fetched in S_EVAL and committed in S_WRITE, which stalls
// while the sink holds the previous result. A word may give no results; a read gives one.
// Throughput is one word at a time: the input stays closed until the previous word is done.
// After reset a sweep zeroes all 2*GRID_SIZE*GRID_SIZE counters while in_i.ready
// stays low; configuration writes are taken during the sweep.
// The block size register resets to 180.
module maze_wall_evidence_update #(
  parameter int GRID_SIZE  = mweu_pkg::GRID_SIZE_DEF,
  parameter int COUNT_BITS = mweu_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mweu_pkg::BLK_W-1:0]  cfg_wdata_i,
  mweu_in_if.sink                     in_i,
  mweu_out_if.source                  out_o
);
  import mweu_pkg::*;

  // The controller and datapath talk only through these two bundles.
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // The controller owns the input handshake; it accepts one word at a time,
  // even while the previous result still sits in the output register.
  mweu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // The datapath holds the counters, walks the ray one cell per result and
  // drives the registered result word.
  mweu_dp #(
    .GRID_SIZE  (GRID_SIZE),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .in_cmd_i      (in_i.cmd),
    .in_cell_x_i   (in_i.cell_x),
    .in_cell_y_i   (in_i.cell_y),
    .in_look_dir_i (in_i.look_dir),
    .in_range_i    (in_i.range_reading),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_x_o       (out_o.out_x),
    .out_y_o       (out_o.out_y),
    .out_wall_o    (out_o.wall_kind),
    .out_count_o   (out_o.new_count),
    .out_touched_o (out_o.touched),
    .out_last_o    (out_o.last)
  );

`ifndef SYNTH
  // Only one word is in flight: right after acceptance the input is closed.
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input accepted twice in a row");

  // A result is never written over one that the sink has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.commit |-> (!out_o.valid || out_o.ready))
    else $error("result register overwritten");

  // No word is taken while the counter memory is being cleared.
  a_clear_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.clear |-> !in_i.ready)
    else $error("input open during clearing sweep");

  // A read-back is always the last and only result of its word.
  a_read_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.commit && dp_stat.act == ACT_READ |=> out_o.valid && out_o.last && !out_o.touched)
    else $error("read result not flagged last");
`endif

endmodule
